@@ hw/rtl/lgpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpd_pkg
// Shared types and constants of the light-gun photodiode detector.
// ----------------------------------------------------------------------------
package lgpd_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int RAD_W       = 4;
  localparam int SUS_W       = 6;
  localparam int THR_W       = 10;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 10;
  localparam int ADD_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // classified request handed from the front to the back
  typedef struct packed {
    op_t              op;
    logic             in_sensor;
    logic             in_window;
    logic [ADD_W-1:0] add;
    logic             last;
  } qentry_t;

endpackage

@@ hw/rtl/lgpd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpd_front
// Accepts requests, latches aim and beam on start, and classifies each
// pixel against the circular sensor and the beam window.
// ----------------------------------------------------------------------------
module lgpd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          q_full,
  input  logic [lgpd_pkg::RAD_W-1:0]    sensor_radius,
  input  logic [lgpd_pkg::SUS_W-1:0]    sustain_lines,
  input  logic                          req_type,
  input  logic [7:0]                    aim_col,
  input  logic [7:0]                    aim_row,
  input  logic [8:0]                    beam_row,
  input  logic [8:0]                    beam_col,
  input  logic signed [9:0]             pixel_col,
  input  logic signed [9:0]             pixel_row,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          last_pixel,
  output logic                          in_stall,
  output logic                          q_push,
  output lgpd_pkg::qentry_t             q_entry
);
  import lgpd_pkg::*;

  localparam logic [RAD_W-1:0] R_MAX = RAD_W'(MAX_RADIUS);

  logic [7:0]  aim_col_reg;
  logic [7:0]  aim_row_reg;
  logic [8:0]  beam_row_reg;
  logic [8:0]  beam_col_reg;

  logic                accept;
  logic                is_pixel;
  logic [RAD_W-1:0]    r_eff;
  logic signed [10:0]  pc11, pr11, dc, dr;
  logic [10:0]         dc_neg, dr_neg;
  logic [9:0]          dc_abs, dr_abs;
  logic                near;
  logic [7:0]          dc_sq, dr_sq, r_sq;
  logic [8:0]          d_sq;
  logic                in_sensor;
  logic signed [10:0]  brow11, bcol11, low11;
  logic                in_window;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_pixel = (req_type == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      aim_col_reg  <= '0;
      aim_row_reg  <= '0;
      beam_row_reg <= '0;
      beam_col_reg <= '0;
    end else if (accept && !is_pixel) begin
      aim_col_reg  <= aim_col;
      aim_row_reg  <= aim_row;
      beam_row_reg <= beam_row;
      beam_col_reg <= beam_col;
    end
  end

  always_comb begin
    r_eff = (sensor_radius > R_MAX) ? R_MAX : sensor_radius;
    pc11  = {pixel_col[9], pixel_col};
    pr11  = {pixel_row[9], pixel_row};
    dc    = pc11 - $signed({3'b000, aim_col_reg});
    dr    = pr11 - $signed({3'b000, aim_row_reg});
    dc_neg = 11'(-dc);
    dr_neg = 11'(-dr);
    dc_abs = dc[10] ? dc_neg[9:0] : dc[9:0];
    dr_abs = dr[10] ? dr_neg[9:0] : dr[9:0];
    // coarse box test keeps the squares down to 4-bit operands
    near  = (dc_abs <= {6'b0, r_eff}) && (dr_abs <= {6'b0, r_eff});
    dc_sq = {4'b0, dc_abs[3:0]} * {4'b0, dc_abs[3:0]};
    dr_sq = {4'b0, dr_abs[3:0]} * {4'b0, dr_abs[3:0]};
    r_sq  = {4'b0, r_eff} * {4'b0, r_eff};
    d_sq  = {1'b0, dc_sq} + {1'b0, dr_sq};
    in_sensor = near && (d_sq <= {1'b0, r_sq});

    brow11 = $signed({2'b00, beam_row_reg});
    bcol11 = $signed({2'b00, beam_col_reg});
    low11  = brow11 - $signed({5'b0, sustain_lines});
    in_window = (pr11 <= brow11) && (pr11 > low11) &&
                ((pr11 != brow11) || (pc11 <= bcol11));
  end

  always_comb begin
    q_push            = accept;
    q_entry.op        = is_pixel ? OP_PIXEL : OP_START;
    q_entry.in_sensor = in_sensor;
    q_entry.in_window = in_window;
    q_entry.add       = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    q_entry.last      = last_pixel;
  end

endmodule

@@ hw/rtl/lgpd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpd_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module lgpd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lgpd_pkg::qentry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output lgpd_pkg::qentry_t head
);
  import lgpd_pkg::*;

  qentry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/lgpd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpd_back
// Applies classified requests to the accumulators, snapshots them on the
// last pixel and forms the threshold decision into the output register.
// ----------------------------------------------------------------------------
module lgpd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  lgpd_pkg::qentry_t           head,
  input  logic [lgpd_pkg::THR_W-1:0]  brightness_threshold,
  input  logic                        out_stall,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic                        light_detected,
  output logic [lgpd_pkg::SUM_W-1:0]  brightness_sum,
  output logic [lgpd_pkg::CNT_W-1:0]  sensor_pixels
);
  import lgpd_pkg::*;

  logic [SUM_W-1:0] sum_acc, sum_acc_next;
  logic [CNT_W-1:0] count_acc, count_acc_next;
  logic [SUM_W:0]   sum_wide;

  logic             snap_valid;
  logic [SUM_W-1:0] snap_sum;
  logic [CNT_W-1:0] snap_count;

  logic             out_adv;
  logic             snap_free;
  logic             is_report;
  logic             capture;
  logic [SUM_W-1:0] thr_prod;

  assign out_adv   = !out_valid || !out_stall;
  assign snap_free = !snap_valid || out_adv;
  assign is_report = (head.op == OP_PIXEL) && head.last;
  assign q_pop     = q_not_empty && (!is_report || snap_free);
  assign capture   = q_pop && is_report;

  always_comb begin
    sum_wide       = {1'b0, sum_acc} + {{(SUM_W + 1 - ADD_W){1'b0}}, head.add};
    sum_acc_next   = sum_acc;
    count_acc_next = count_acc;
    unique case (head.op)
      OP_START: begin
        sum_acc_next   = '0;
        count_acc_next = '0;
      end
      OP_PIXEL: begin
        if (head.in_sensor) begin
          if (head.in_window) begin
            sum_acc_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
          end
          if (count_acc != CNT_MAX) begin
            count_acc_next = count_acc + 1'b1;
          end
        end
      end
      default: begin
        sum_acc_next   = sum_acc;
        count_acc_next = count_acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc   <= '0;
      count_acc <= '0;
    end else if (q_pop) begin
      sum_acc   <= sum_acc_next;
      count_acc <= count_acc_next;
    end
  end

  // snapshot stage: holds the totals of a finished detection
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (capture) begin
      snap_valid <= 1'b1;
    end else if (out_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      snap_sum   <= sum_acc_next;
      snap_count <= count_acc_next;
    end
  end

  // 1023 * 1023 fits in the sum width
  assign thr_prod = {{(SUM_W - THR_W){1'b0}}, brightness_threshold} *
                    {{(SUM_W - CNT_W){1'b0}}, snap_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && snap_valid) begin
      light_detected <= (snap_sum >= thr_prod);
      brightness_sum <= snap_sum;
      sensor_pixels  <= snap_count;
    end
  end

endmodule

@@ hw/rtl/light_gun_photodiode_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_gun_photodiode_detector
// Light-gun sensor model: circular sensor, beam window, brightness test.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a start request (req_type 0)
//   latches aim and beam and clears the totals; pixel requests
//   (req_type 1) are tested against the sensor circle and the beam window.
//   A pixel request with last_pixel set yields one result on the output
//   channel (out_valid / out_stall); other requests yield none.
//   Throughput: one request per cycle while in_stall is low. The front
//   classifies a request in the cycle it is taken and writes it to a
//   4-entry queue; the back pops one entry per cycle into the accumulators,
//   except that a last pixel waits while a full snapshot register cannot
//   move on to the stalled output. A result passes from the queue through
//   the snapshot register and the multiply-compare into the output register.
//   in_stall rises only while the queue is full, which happens when the
//   receiver holds out_stall and results back up through the snapshot and
//   output registers. A stalled result holds steady.
//   Reset: registers return to radius 3, sustain 22, threshold 192; aim,
//   beam and totals clear. The user must write configuration through cfg_we,
//   cfg_index and cfg_data only while idle; the block has no check for it.
// ----------------------------------------------------------------------------
module light_gun_photodiode_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lgpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [7:0]                         aim_col,
  input  logic [7:0]                         aim_row,
  input  logic [8:0]                         beam_row,
  input  logic [8:0]                         beam_col,
  input  logic signed [9:0]                  pixel_col,
  input  logic signed [9:0]                  pixel_row,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic                               last_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               light_detected,
  output logic [lgpd_pkg::SUM_W-1:0]         brightness_sum,
  output logic [lgpd_pkg::CNT_W-1:0]         sensor_pixels
);
  import lgpd_pkg::*;

  logic [RAD_W-1:0] sensor_radius;
  logic [SUS_W-1:0] sustain_lines;
  logic [THR_W-1:0] brightness_threshold;

  logic    q_push;
  qentry_t q_entry;
  logic    q_pop;
  logic    q_full;
  logic    q_not_empty;
  qentry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_radius        <= RAD_W'(3);
      sustain_lines        <= SUS_W'(22);
      brightness_threshold <= THR_W'(192);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:    sensor_radius        <= cfg_data[RAD_W-1:0];
        CFG_SUSTAIN:   sustain_lines        <= cfg_data[SUS_W-1:0];
        CFG_THRESHOLD: brightness_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  lgpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .q_full        (q_full),
    .sensor_radius (sensor_radius),
    .sustain_lines (sustain_lines),
    .req_type      (req_type),
    .aim_col       (aim_col),
    .aim_row       (aim_row),
    .beam_row      (beam_row),
    .beam_col      (beam_col),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_pixel    (last_pixel),
    .in_stall      (in_stall),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  lgpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  lgpd_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_not_empty          (q_not_empty),
    .head                 (q_head),
    .brightness_threshold (brightness_threshold),
    .out_stall            (out_stall),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .light_detected       (light_detected),
    .brightness_sum       (brightness_sum),
    .sensor_pixels        (sensor_pixels)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the light-gun photodiode detector.
// A table of directed requests covers reset values, coordinate and register
// extremes and carried-over totals; a long detection then saturates both totals.
// Random detection sequences follow under several register settings. Every
// result is checked against a cycle-free predictor or a hand-typed table
// result. Both channels see random gaps and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import lgpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index
  localparam int SETTLE_CYCLES = 12;                  // queue + pipeline flush

  typedef struct packed {
    op_t        kind;
    logic [7:0] a_col;
    logic [7:0] a_row;
    logic [8:0] b_row;
    logic [8:0] b_col;
    logic [9:0] p_col;
    logic [9:0] p_row;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } req_t;

  typedef struct packed {
    logic             light;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } res_t;

  // wr rows write a register; fixed rows carry a hand-typed result
  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    req_t                  rq;
    logic                  fixed;
    res_t                  res;
  } row_t;

  localparam int DIR_N = 31;
  localparam row_t DIR_ROWS [DIR_N] = '{
    // reset settings: empty sensor, then totals kept across results
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd511, 10'd511,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b1, 20'd0, 10'd0}},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b1, 20'd765, 10'd1}},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b1, 20'd1530, 10'd2}},
    // start with last set: pixel fields ignored
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_START, 8'd100, 8'd100, 9'd110, 9'd100, -10'sd1,
      -10'sd1, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd255, 8'd255, 9'd511, 9'd511, 10'd100,
      10'd100, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    // last pixel outside the sensor still reports
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, -10'sd16, -10'sd16,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b0, 20'd0, 10'd1}},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_START, 8'd255, 8'd255, 9'd511, 9'd511, 10'd0,
      10'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd258, 10'd255,
      8'd200, 8'd200, 8'd200, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd255, 10'd252,
      8'd17, 8'd34, 8'd68, 1'b1}, 1'b0, '0},
    // point sensor, empty beam window, zero threshold
    '{1'b1, CFG_RADIUS, 10'd0, '0, 1'b0, '0},
    '{1'b1, CFG_SUSTAIN, 10'd0, '0, 1'b0, '0},
    '{1'b1, CFG_THRESHOLD, 10'd0, '0, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_START, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0,
      8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b1, 20'd0, 10'd1}},
    // widest sensor and window, top threshold
    '{1'b1, CFG_RADIUS, 10'd15, '0, 1'b0, '0},
    '{1'b1, CFG_SUSTAIN, 10'd63, '0, 1'b0, '0},
    '{1'b1, CFG_THRESHOLD, 10'd1023, '0, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_START, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0,
      8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, -10'sd15, 10'd0,
      8'd1, 8'd2, 8'd3, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd0, -10'sd15,
      8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd11, 10'd11,
      8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd1, 10'd0,
      8'd128, 8'd128, 8'd128, 1'b1}, 1'b0, '0},
    // single-line window: beam row cut at beam column
    '{1'b1, CFG_SUSTAIN, 10'd1, '0, 1'b0, '0},
    '{1'b1, CFG_THRESHOLD, 10'd765, '0, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_START, 8'd50, 8'd50, 9'd50, 9'd49, 10'd0, 10'd0,
      8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd49, 10'd50,
      8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd50, 10'd49,
      8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd50, 10'd50,
      8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0},
    // unmapped index is a no-op; upper data bits are dropped
    '{1'b1, CFG_SPARE, 10'h3FF, '0, 1'b0, '0},
    '{1'b1, CFG_RADIUS, 10'h3F3, '0, 1'b0, '0},
    '{1'b0, CFG_RADIUS, 10'd0, '{OP_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 10'd50, 10'd53,
      8'd90, 8'd9, 8'd200, 1'b1}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = 1'b0;
  logic [7:0]            aim_col = '0;
  logic [7:0]            aim_row = '0;
  logic [8:0]            beam_row = '0;
  logic [8:0]            beam_col = '0;
  logic signed [9:0]     pixel_col = '0;
  logic signed [9:0]     pixel_row = '0;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic                  last_pixel = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  light_detected;
  logic [SUM_W-1:0]      brightness_sum;
  logic [CNT_W-1:0]      sensor_pixels;

  // predictor state
  logic [RAD_W-1:0] cfg_radius = 4'd3;
  logic [SUS_W-1:0] cfg_sustain = 6'd22;
  logic [THR_W-1:0] cfg_thresh = 10'd192;
  logic [7:0]       lat_acol = '0;
  logic [7:0]       lat_arow = '0;
  logic [8:0]       lat_brow = '0;
  logic [8:0]       lat_bcol = '0;
  logic [SUM_W-1:0] acc_sum = '0;
  logic [CNT_W-1:0] acc_cnt = '0;

  res_t expected_readings [$];

  bit idle_tx = 1'b1;
  bit idle_rx = 1'b1;
  int hold_left = 0;
  int choke_left = 0;
  int n_errors = 0;
  int n_reqs = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_held = 0;

  light_gun_photodiode_detector dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Timeout: detector stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  task automatic log_mismatch(input string what);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Advances the detector state by one request; returns 1 with the reading
  // when the request closes a detection.
  function automatic bit predict_reading(input req_t rq, output res_t rd);
    int pc, pr, dc, dr, rad, row_b, total;
    rd = '0;
    if (rq.kind == OP_START) begin
      lat_acol = rq.a_col;
      lat_arow = rq.a_row;
      lat_brow = rq.b_row;
      lat_bcol = rq.b_col;
      acc_sum = '0;
      acc_cnt = '0;
      return 1'b0;
    end
    rad = (int'(cfg_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius);
    pc = int'($signed(rq.p_col));
    pr = int'($signed(rq.p_row));
    dc = pc - int'(lat_acol);
    dr = pr - int'(lat_arow);
    row_b = int'(lat_brow);
    if (dc * dc + dr * dr <= rad * rad) begin
      if (pr <= row_b && pr > row_b - int'(cfg_sustain) &&
          (pr != row_b || pc <= int'(lat_bcol))) begin
        total = int'(acc_sum) + int'(rq.r) + int'(rq.g) + int'(rq.b);
        acc_sum = (total > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
      end
      if (acc_cnt != CNT_MAX) acc_cnt = acc_cnt + 1'b1;
    end
    if (!rq.last) return 1'b0;
    rd.light = int'(acc_sum) >= int'(cfg_thresh) * int'(acc_cnt);
    rd.sum = acc_sum;
    rd.cnt = acc_cnt;
    return 1'b1;
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    rq.kind = $urandom_range(0, 1) ? OP_PIXEL : OP_START;
    rq.a_col = 8'($urandom);
    rq.a_row = 8'($urandom);
    rq.b_row = 9'($urandom);
    rq.b_col = 9'($urandom);
    rq.p_col = 10'($urandom_range(0, 527) - 16);
    rq.p_row = 10'($urandom_range(0, 527) - 16);
    case ($urandom_range(0, 7))
      0:       {rq.r, rq.g, rq.b} = 24'hFFFFFF;
      1:       {rq.r, rq.g, rq.b} = 24'h000000;
      default: {rq.r, rq.g, rq.b} = 24'($urandom);
    endcase
    rq.last = 1'($urandom);
    return rq;
  endfunction

  // beam placed around the aim point most of the time so the window matters
  function automatic req_t gen_start();
    req_t rq;
    int span;
    rq = rand_req();
    rq.kind = OP_START;
    span = int'(cfg_radius) + 2;
    if ($urandom_range(0, 7) == 0) rq.a_col = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 7) == 0) rq.a_row = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 3) != 0)
      rq.b_row = 9'(clamp_int(int'(rq.a_row) + int'($urandom_range(0, 30)) - 8, 0, 511));
    if ($urandom_range(0, 3) != 0)
      rq.b_col = 9'(clamp_int(int'(rq.a_col) + int'($urandom_range(0, 2 * span)) - span,
                              0, 511));
    return rq;
  endfunction

  function automatic req_t gen_pixel(input logic last);
    req_t rq;
    int span;
    rq = rand_req();
    rq.kind = OP_PIXEL;
    rq.last = last;
    span = int'(cfg_radius) + 2;
    if ($urandom_range(0, 4) != 0) begin
      rq.p_col = 10'(clamp_int(int'(lat_acol) + int'($urandom_range(0, 2 * span)) - span,
                               -16, 511));
      rq.p_row = 10'(clamp_int(int'(lat_arow) + int'($urandom_range(0, 2 * span)) - span,
                               -16, 511));
    end
    return rq;
  endfunction

  // Starts at a falling edge is not assumed; returns at the accepting edge.
  task automatic send_req(input req_t rq, input logic fixed, input res_t fixed_res);
    int gap;
    res_t rd;
    gap = idle_tx ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type   <= rq.kind;
    aim_col    <= rq.a_col;
    aim_row    <= rq.a_row;
    beam_row   <= rq.b_row;
    beam_col   <= rq.b_col;
    pixel_col  <= rq.p_col;
    pixel_row  <= rq.p_row;
    red        <= rq.r;
    green      <= rq.g;
    blue       <= rq.b;
    last_pixel <= rq.last;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_reqs++;
    if (predict_reading(rq, rd)) expected_readings.push_back(fixed ? fixed_res : rd);
  endtask

  // Drops the request line and waits out every pending result plus the
  // requests that produce none.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    case (idx)
      CFG_RADIUS:    cfg_radius  = val[RAD_W-1:0];
      CFG_SUSTAIN:   cfg_sustain = val[SUS_W-1:0];
      CFG_THRESHOLD: cfg_thresh  = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly complete detections with random content, some continuations on
  // the previous totals, and loose requests of either kind.
  task automatic run_traffic(input int n_items);
    int sent, len, pick;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 15) == 0) begin
        idle_tx = $urandom_range(0, 2) != 0;
        idle_rx = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_req(gen_start(), 1'b0, '0);
        len = $urandom_range(0, 10);
        repeat (len) send_req(gen_pixel(1'b0), 1'b0, '0);
        send_req(gen_pixel(1'b1), 1'b0, '0);
        sent += len + 2;
      end else if (pick == 7) begin
        len = $urandom_range(1, 4);
        repeat (len) send_req(gen_pixel(1'b0), 1'b0, '0);
        send_req(gen_pixel(1'b1), 1'b0, '0);
        sent += len + 1;
      end else begin
        send_req(rand_req(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (choke_left > 0) begin
      out_stall <= 1'b1;
      choke_left--;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst) begin
      if (in_valid && in_stall) n_held++;
      if (out_valid && !out_stall) begin
        n_results++;
        hold_left = idle_rx ? $urandom_range(0, 14) : 0;
        if (expected_readings.size() == 0) begin
          log_mismatch("result with no detection pending");
        end else begin
          want = expected_readings.pop_front();
          if (light_detected !== want.light)
            log_mismatch($sformatf("light_detected got %b want %b",
                                   light_detected, want.light));
          if (brightness_sum !== want.sum)
            log_mismatch($sformatf("brightness_sum got %0d want %0d",
                                   brightness_sum, want.sum));
          if (sensor_pixels !== want.cnt)
            log_mismatch($sformatf("sensor_pixels got %0d want %0d",
                                   sensor_pixels, want.cnt));
        end
      end
    end
  end

  initial begin
    req_t rq;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].wr) begin
        drain();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
      end else begin
        send_req(DIR_ROWS[i].rq, DIR_ROWS[i].fixed, DIR_ROWS[i].res);
      end
    end

    // long detection on the aim point: count and sum both saturate
    drain();
    write_reg(CFG_RADIUS, 10'd15);
    write_reg(CFG_SUSTAIN, 10'd63);
    rq = rand_req();
    rq.kind = OP_START;
    rq.a_col = 8'd128;
    rq.a_row = 8'd128;
    rq.b_row = 9'd130;
    rq.b_col = 9'd0;
    send_req(rq, 1'b0, '0);
    for (int k = 0; k < 1400; k++) begin
      rq = rand_req();
      rq.kind = OP_PIXEL;
      rq.p_col = 10'(125 + $urandom_range(0, 6));
      rq.p_row = 10'(125 + $urandom_range(0, 4));
      {rq.r, rq.g, rq.b} = 24'hFFFFFF;
      rq.last = (k == 1022 || k == 1023 || k == 1399);
      send_req(rq, 1'b0, '0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_RADIUS, 10'($urandom_range(1, 15)));
          write_reg(CFG_SUSTAIN, 10'($urandom_range(1, 63)));
          write_reg(CFG_THRESHOLD, 10'($urandom_range(0, 765)));
        end
        1: begin
          write_reg(CFG_RADIUS, 10'd15);
          write_reg(CFG_SUSTAIN, 10'd63);
          write_reg(CFG_THRESHOLD, 10'($urandom_range(0, 300)));
        end
        2: begin
          write_reg(CFG_RADIUS, 10'd1);
          write_reg(CFG_SUSTAIN, 10'd1);
          write_reg(CFG_THRESHOLD, 10'($urandom_range(0, 765)));
        end
        default: begin
          write_reg(CFG_RADIUS, {6'($urandom), 4'($urandom_range(1, 15))});
          write_reg(CFG_SUSTAIN, {4'($urandom), 6'($urandom_range(1, 63))});
          write_reg(CFG_THRESHOLD, 10'($urandom));
        end
      endcase
      run_traffic(250);
      if (ph == 1) begin
        // receiver goes quiet while requests keep coming, so the input backs up
        drain();
        @(posedge clk);
        choke_left = 160;
        idle_tx = 1'b0;
        repeat (30) send_req(gen_pixel(1'b1), 1'b0, '0);
        idle_tx = 1'b1;
      end
    end

    drain();
    $display("Run covered %0d requests, %0d results, %0d register writes",
             n_reqs, n_results, n_writes);
    $display("Input was held off for %0d cycles by output back-pressure", n_held);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
